@@ rtl/core/height_to_normal_map_top_assert.svh @@
// Assertion macros used by the normal-map RTL back end, hnm_back.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef HEIGHT_TO_NORMAL_MAP_TOP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_TOP_ASSERT_SVH

// Same-cycle implication
`define HNM_ASSERT_HOLD(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HNM_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hnm_pkg.sv @@
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants for the height-to-normal-map converter.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_ROWS  = 4096;
  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int CFG_W     = 13;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDX_ALPHA  = 2'd2;

  // Arithmetic sizes
  localparam int SLOPE_W   = 11;   // 3 * (a - b), signed
  localparam int SUM_W     = 21;   // dx^2 + dy^2 + 65025
  localparam int RAD_W     = 54;   // sum << 32, padded to even
  localparam int ROOT_W    = 27;
  localparam int SREM_W    = 29;
  localparam int NUM_W     = 42;   // magnitude << 32
  localparam int QUO_W     = 18;
  localparam int STEP_W    = 6;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int DIV_STEPS  = NUM_W;
  localparam logic [ROOT_W-1:0] LQ_MIN   = ROOT_W'(255 * 65536);
  localparam logic [QUO_W-1:0]  Q_Z_MAX  = QUO_W'(65536);
  localparam logic [SUM_W-1:0]  SUM_BIAS = SUM_W'(65025);

  typedef struct packed {
    logic       mode;
    logic [7:0] height_sample;
  } hnm_in_t;

  typedef struct packed {
    logic [7:0] normal_x;
    logic [7:0] normal_y;
    logic [7:0] normal_z;
    logic [7:0] alpha_out;
    logic       frame_last;
  } hnm_out_t;

  // One pixel handed from the front to the back
  typedef struct packed {
    logic [7:0] center;
    logic [7:0] right;
    logic [7:0] below;
    logic [7:0] alpha;
    logic       last;
  } hnm_job_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             alpha_en;
    logic             restart;
  } hnm_cfg_t;

  typedef enum logic [1:0] {F_IDLE, F_RD0, F_RD1} hnm_fstate_t;
  typedef enum logic [2:0] {B_IDLE, B_SUM, B_SQRT, B_DIV, B_DONE} hnm_bstate_t;

endpackage

@@ rtl/core/hnm_ram.sv @@
// ----------------------------------------------------------------------------
// hnm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hnm_queue.sv @@
// ----------------------------------------------------------------------------
// hnm_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module hnm_queue
  import hnm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  hnm_job_t wr_job,
  output logic     q_full,
  input  logic     rd_en,
  output hnm_job_t rd_job,
  output logic     q_empty
);

  hnm_job_t   slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_job  = slot_r[rptr_r];

  // Hold payload
  always_ff @(posedge clk) begin
    if (wr_en && !q_full) begin
      slot_r[wptr_r] <= wr_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en && !q_full) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_en && !q_empty) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'((wr_en && !q_full) ? 1 : 0) - 2'((rd_en && !q_empty) ? 1 : 0);
    end
  end

endmodule

@@ rtl/core/hnm_front.sv @@
// ----------------------------------------------------------------------------
// hnm_front
// Accepts samples and drain ticks, walks the row stores and forms jobs.
// ----------------------------------------------------------------------------
module hnm_front
  import hnm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  hnm_cfg_t cfg,
  input  logic     push,
  input  hnm_in_t  in_data,
  output logic     full,
  output logic     job_wr,
  output hnm_job_t job,
  input  logic     job_full
);

  hnm_fstate_t state_r, state_nxt;
  logic          mode_r;
  logic [7:0]    smp_r, c_r, pfp_r;
  logic [AW-1:0] col_r, drn_r, addr_r;
  logic [CFG_W-1:0] row_r;

  logic          accept, item_ok, need_push, advance;
  logic [AW-1:0] drn_eff, addr0, addr1, prev_raddr, first_raddr;
  logic [CFG_W-1:0] addr_ext1, col_ext1;
  logic          last, right_in;
  logic [7:0]    prev_rdata, first_rdata;
  logic          prev_we, first_we;

  assign full   = (state_r != F_IDLE);
  assign accept = push && !full;

  // Classify the incoming item
  always_comb begin
    drn_eff = ({1'b0, drn_r} >= cfg.width) ? AW'(cfg.width - CFG_W'(1)) : drn_r;
    addr0   = in_data.mode ? drn_eff : col_r;
    if (in_data.mode) begin
      item_ok = (row_r >= cfg.height);
    end else begin
      item_ok = (row_r < cfg.height) && ({1'b0, col_r} < cfg.width);
    end
  end

  // Neighbour address and end-of-row flags
  always_comb begin
    addr_ext1 = {1'b0, addr_r} + CFG_W'(1);
    col_ext1  = {1'b0, col_r} + CFG_W'(1);
    right_in  = (addr_ext1 < cfg.width);
    last      = !right_in;
    addr1     = right_in ? AW'(addr_ext1) : '0;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept && item_ok) state_nxt = F_RD0;
      F_RD0:   state_nxt = F_RD1;
      F_RD1:   if (advance) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs and store controls
  always_comb begin
    need_push   = mode_r || (row_r != '0);
    advance     = (state_r == F_RD1) && (!need_push || !job_full);
    job_wr      = (state_r == F_RD1) && need_push && !job_full;
    prev_we     = advance && !mode_r;
    first_we    = prev_we && (row_r == '0);
    prev_raddr  = (state_r == F_IDLE) ? addr0 : addr1;
    first_raddr = (state_r == F_IDLE) ? addr0 : addr_r;
    job.center  = c_r;
    job.right   = (mode_r || (col_ext1 < cfg.width)) ? prev_rdata : pfp_r;
    job.below   = mode_r ? first_rdata : smp_r;
    job.alpha   = cfg.alpha_en ? c_r : 8'd0;
    job.last    = mode_r && last;
  end

  hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prev_row (
    .clk   (clk),
    .we    (prev_we),
    .waddr (col_r),
    .wdata (smp_r),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_first_row (
    .clk   (clk),
    .we    (first_we),
    .waddr (col_r),
    .wdata (smp_r),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  // Hold item payload and store reads
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_data.mode;
      smp_r  <= in_data.height_sample;
      addr_r <= addr0;
    end
    if (state_r == F_RD0) begin
      c_r <= prev_rdata;
    end
  end

  // Advance counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      drn_r   <= '0;
      pfp_r   <= 8'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_RD0 && !mode_r && col_r == '0) begin
        pfp_r <= prev_rdata;
      end
      if (cfg.restart) begin
        col_r <= '0;
        row_r <= '0;
        drn_r <= '0;
      end else if (advance) begin
        if (mode_r) begin
          if (last) begin
            drn_r <= '0;
            row_r <= '0;
            col_r <= '0;
          end else begin
            drn_r <= AW'(addr_ext1);
          end
        end else if (col_ext1 >= cfg.width) begin
          col_r <= '0;
          row_r <= row_r + CFG_W'(1);
        end else begin
          col_r <= AW'(col_ext1);
        end
      end
    end
  end

endmodule

@@ rtl/core/hnm_back.sv @@
// ----------------------------------------------------------------------------
// hnm_back
// Computes one encoded normal per job: squared length, bit-serial square
// root, three parallel bit-serial divisions, then encode into the result.
// ----------------------------------------------------------------------------
module hnm_back
  import hnm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  hnm_job_t q_job,
  output logic     q_rd,
  output logic     empty,
  input  logic     pop,
  output hnm_out_t out_data
);

  `include "height_to_normal_map_top_assert.svh"

  hnm_bstate_t state_r, state_nxt;
  logic signed [SLOPE_W-1:0] dx_r, dy_r;
  logic [7:0]        alpha_r;
  logic              last_r;
  logic [RAD_W-1:0]  rad_r;
  logic [SREM_W-1:0] srem_r;
  logic [ROOT_W-1:0] root_r;
  logic [STEP_W-1:0] cnt_r;
  logic [NUM_W-1:0]  num_r  [3];
  logic [ROOT_W-1:0] drem_r [3];
  logic [QUO_W-1:0]  q_r    [3];
  logic              neg_r  [3];
  logic              out_valid_r;
  hnm_out_t          out_r;

  logic              out_free, step_done;
  logic [SUM_W-1:0]  sum;
  logic [SREM_W+1:0] trial, tsub;
  logic [ROOT_W:0]   dcand [3];
  logic [9:0]        mag_x, mag_y;

  function automatic logic [7:0] encode(input logic [QUO_W-1:0] q, input logic neg);
    logic [24:0]        p;
    logic signed [26:0] v;
    p = {q, 7'b0} - 25'(q);
    v = neg ? (27'sd8388608 - $signed({2'b0, p})) : (27'sd8388608 + $signed({2'b0, p}));
    if (v < 0) begin
      encode = 8'd0;
    end else if (v[26:16] > 11'd255) begin
      encode = 8'd255;
    end else begin
      encode = v[23:16];
    end
  endfunction

  assign out_free  = !out_valid_r || pop;
  assign step_done = (cnt_r == '0);
  assign empty     = !out_valid_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_SUM;
      B_SUM:   state_nxt = B_SQRT;
      B_SQRT:  if (step_done) state_nxt = B_DIV;
      B_DIV:   if (step_done) state_nxt = B_DONE;
      B_DONE:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Datapath terms
  always_comb begin
    q_rd  = (state_r == B_IDLE) && !q_empty;
    sum   = SUM_W'(dx_r * dx_r) + SUM_W'(dy_r * dy_r) + SUM_BIAS;
    trial = {srem_r, rad_r[RAD_W-1 -: 2]};
    tsub  = {2'b0, root_r, 2'b01};
    mag_x = dx_r[SLOPE_W-1] ? 10'(-dx_r) : 10'(dx_r);
    mag_y = dy_r[SLOPE_W-1] ? 10'(-dy_r) : 10'(dy_r);
    for (int i = 0; i < 3; i++) begin
      dcand[i] = {drem_r[i], num_r[i][NUM_W-1]};
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        dx_r    <= SLOPE_W'(3) * ($signed({3'b0, q_job.center}) - $signed({3'b0, q_job.right}));
        dy_r    <= SLOPE_W'(3) * ($signed({3'b0, q_job.center}) - $signed({3'b0, q_job.below}));
        alpha_r <= q_job.alpha;
        last_r  <= q_job.last;
      end
      B_SUM: begin
        rad_r  <= {1'b0, sum, 32'b0};
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= STEP_W'(SQRT_STEPS - 1);
      end
      B_SQRT: begin
        if (trial >= tsub) begin
          srem_r <= SREM_W'(trial - tsub);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r <= SREM_W'(trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        rad_r <= {rad_r[RAD_W-3:0], 2'b00};
        if (step_done) begin
          num_r[0] <= {mag_y, 32'b0};
          num_r[1] <= {mag_x, 32'b0};
          num_r[2] <= {10'd255, 32'b0};
          neg_r[0] <= dy_r[SLOPE_W-1];
          neg_r[1] <= !dx_r[SLOPE_W-1] && (dx_r != '0);
          neg_r[2] <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            drem_r[i] <= '0;
            q_r[i]    <= '0;
          end
          cnt_r <= STEP_W'(DIV_STEPS - 1);
        end else begin
          cnt_r <= cnt_r - STEP_W'(1);
        end
      end
      B_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (dcand[i] >= {1'b0, root_r}) begin
            drem_r[i] <= ROOT_W'(dcand[i] - {1'b0, root_r});
            q_r[i]    <= {q_r[i][QUO_W-2:0], 1'b1};
          end else begin
            drem_r[i] <= ROOT_W'(dcand[i]);
            q_r[i]    <= {q_r[i][QUO_W-2:0], 1'b0};
          end
          num_r[i] <= {num_r[i][NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - STEP_W'(1);
      end
      default: ;
    endcase
    if (state_r == B_DONE && out_free) begin
      out_r.normal_x   <= encode(q_r[0], neg_r[0]);
      out_r.normal_y   <= encode(q_r[1], neg_r[1]);
      out_r.normal_z   <= encode(q_r[2], neg_r[2]);
      out_r.alpha_out  <= alpha_r;
      out_r.frame_last <= last_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `HNM_ASSERT_NEXT(a_lq_floor, state_r == B_SQRT && step_done, root_r >= LQ_MIN, "length below floor")
  `HNM_ASSERT_HOLD(a_div_rem, state_r == B_DIV, drem_r[0] < root_r && drem_r[1] < root_r && drem_r[2] < root_r, "division remainder out of range")
  `HNM_ASSERT_HOLD(a_qz_bound, state_r == B_DONE, q_r[2] <= Q_Z_MAX, "z quotient too large")

endmodule

@@ rtl/core/height_to_normal_map_top.sv @@
// ----------------------------------------------------------------------------
// height_to_normal_map_top
// Streaming height-map to normal-map converter with configuration port.
//
//   channel | ports                     | transfer when
//   input   | push, full, in_data       | push && !full
//   result  | empty, pop, out_data      | pop && !empty
//   config  | cfg_we, cfg_index, cfg_wdata | cfg_we
//
// The front handles an item in states F_RD0 and F_RD1 (two row-store reads
// and a write) and holds full high until it returns to F_IDLE. The back
// takes one job at a time; 27 square-root steps and 42 steps of the three
// parallel dividers set its rate. Reset is synchronous; row stores need no
// clearing and the block is ready as soon as reset is released. A two-entry
// job queue decouples the front from the back, and the result register lets
// the back work on the next pixel while pop is held low.
// ----------------------------------------------------------------------------
module height_to_normal_map_top
  import hnm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  hnm_in_t          in_data,
  output logic             empty,
  input  logic             pop,
  output hnm_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] width_r, height_r;
  logic             alpha_r;
  hnm_cfg_t         cfg;
  logic             job_wr, job_full, job_rd, job_empty;
  hnm_job_t         job_in, job_out;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(256);
      height_r <= CFG_W'(256);
      alpha_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        CFG_IDX_ALPHA:  alpha_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp frame size
  always_comb begin
    if (width_r == '0) begin
      cfg.width = CFG_W'(1);
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      cfg.width = CFG_W'(MAX_WIDTH);
    end else begin
      cfg.width = width_r;
    end
    if (height_r == '0) begin
      cfg.height = CFG_W'(1);
    end else if (height_r > CFG_W'(MAX_ROWS)) begin
      cfg.height = CFG_W'(MAX_ROWS);
    end else begin
      cfg.height = height_r;
    end
    cfg.alpha_en = alpha_r;
    cfg.restart  = cfg_we && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT);
  end

  hnm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .job_wr   (job_wr),
    .job      (job_in),
    .job_full (job_full)
  );

  hnm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_wr),
    .wr_job  (job_in),
    .q_full  (job_full),
    .rd_en   (job_rd),
    .rd_job  (job_out),
    .q_empty (job_empty)
  );

  hnm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (job_empty),
    .q_job    (job_out),
    .q_rd     (job_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
